[hdl/srdc_pkg.sv]
// Shared types and constants for the sliding range distinct counter.
package srdc_pkg;

	// Fixed payload widths
	localparam int POS_W   = 12;
	localparam int VAL_W   = 12;
	localparam int BOUND_W = 13;
	localparam int OUT_W   = 13;

	// Input command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_L_CHK,
		ST_L_CRD,
		ST_L_CWR,
		ST_L_NRD,
		ST_L_NWR,
		ST_PICK,
		ST_Q_CRD,
		ST_Q_CWR,
		ST_RESULT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear_en;     // write zero at the sweep address
		logic capture;      // latch the accepted transaction
		logic rd_load;      // element read at the load position
		logic set_down;     // next count update removes an occurrence
		logic set_up;       // next count update adds an occurrence
		logic ld_write;     // write the loaded value into the element store
		logic pick;         // move one window edge by one position
		logic cnt_rd_elem;  // count read at the value just read from the store
		logic cnt_rd_new;   // count read at the loaded value
		logic cnt_write;    // write back the updated count
		logic result;       // load the output register
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_done;
		logic pos_ok;
		logic in_win;
		logic bad;
		logic move_any;
		logic out_busy;
	} sts_t;

endpackage

[hdl/srdc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module srdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/srdc_ctrl.sv]
// Controller state machine of the sliding range distinct counter.
module srdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             cmd,
	output logic             in_ready,
	input  srdc_pkg::sts_t   sts,
	output srdc_pkg::ctl_t   ctl
);
	import srdc_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = (cmd == CMD_LOAD) ? ST_L_CHK : ST_PICK;
				end
			end
			ST_L_CHK: begin
				state_nx = sts.in_win ? ST_L_CRD : ST_IDLE;
			end
			ST_L_CRD:  state_nx = ST_L_CWR;
			ST_L_CWR:  state_nx = ST_L_NRD;
			ST_L_NRD:  state_nx = ST_L_NWR;
			ST_L_NWR:  state_nx = ST_IDLE;
			ST_PICK: begin
				if (sts.bad || !sts.move_any) begin
					state_nx = ST_RESULT;
				end else begin
					state_nx = ST_Q_CRD;
				end
			end
			ST_Q_CRD:  state_nx = ST_Q_CWR;
			ST_Q_CWR:  state_nx = ST_PICK;
			ST_RESULT: begin
				if (!sts.out_busy) state_nx = ST_IDLE;
			end
			default:   state_nx = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: ctl.clear_en = 1'b1;
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.capture = in_valid;
			end
			ST_L_CHK: begin
				ctl.rd_load  = 1'b1;
				ctl.set_down = 1'b1;
				ctl.ld_write = sts.pos_ok && !sts.in_win;
			end
			ST_L_CRD: ctl.cnt_rd_elem = 1'b1;
			ST_L_CWR: ctl.cnt_write   = 1'b1;
			ST_L_NRD: begin
				ctl.cnt_rd_new = 1'b1;
				ctl.set_up     = 1'b1;
			end
			ST_L_NWR: begin
				ctl.cnt_write = 1'b1;
				ctl.ld_write  = 1'b1;
			end
			ST_PICK: begin
				ctl.pick = !sts.bad && sts.move_any;
			end
			ST_Q_CRD:  ctl.cnt_rd_elem = 1'b1;
			ST_Q_CWR:  ctl.cnt_write   = 1'b1;
			ST_RESULT: ctl.result      = !sts.out_busy;
			default:   ctl = '0;
		endcase
	end
endmodule

[hdl/srdc_dp.sv]
// Datapath of the sliding range distinct counter: window, stores and output register.
module srdc_dp #(
	parameter int MAX_ELEMS  = 4096,
	parameter int VALUE_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  srdc_pkg::ctl_t              ctl,
	output srdc_pkg::sts_t              sts,
	input  logic [srdc_pkg::POS_W-1:0]   position,
	input  logic [srdc_pkg::VAL_W-1:0]   value,
	input  logic [srdc_pkg::BOUND_W-1:0] left_bound,
	input  logic [srdc_pkg::BOUND_W-1:0] right_bound,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [srdc_pkg::OUT_W-1:0]   distinct_count,
	output logic                        bad_range
);
	import srdc_pkg::*;

	localparam int EIDX_W    = $clog2(MAX_ELEMS);
	localparam int WIN_W     = $clog2(MAX_ELEMS + 1);
	localparam int CNT_W     = WIN_W;
	localparam int VSPAN     = 1 << VALUE_BITS;
	localparam int CLR_DEPTH = (MAX_ELEMS > VSPAN) ? MAX_ELEMS : VSPAN;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	logic [CLR_W-1:0]      clr_q;
	logic [EIDX_W-1:0]     pos_q;
	logic                  pos_ok_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [WIN_W-1:0]      l_q, r_q;
	logic [WIN_W-1:0]      low_q, high_q;
	logic [WIN_W-1:0]      dist_q;
	logic [VALUE_BITS-1:0] vidx_q;
	logic                  up_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      distinct_q;
	logic                  bad_q;

	logic                  up_lo, up_hi, dn_lo, dn_hi;
	logic [WIN_W-1:0]      step_pos;
	logic [WIN_W-1:0]      pos_ext;
	logic                  bad;

	logic                  elm_we;
	logic [EIDX_W-1:0]     elm_waddr, elm_raddr;
	logic [VALUE_BITS-1:0] elm_wdata, elm_rdata;
	logic                  cnt_we;
	logic [VALUE_BITS-1:0] cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0]      cnt_wdata, cnt_rdata;
	logic [CNT_W-1:0]      cnt_upd;
	logic [WIN_W-1:0]      dist_upd;

	// Edge movement decisions, in the order the window is grown then shrunk
	assign up_lo   = low_q > l_q;
	assign up_hi   = high_q < r_q;
	assign dn_lo   = low_q < l_q;
	assign dn_hi   = high_q > r_q;
	assign bad     = l_q > r_q;
	assign pos_ext = WIN_W'(pos_q);

	always_comb begin
		if (up_lo) begin
			step_pos = low_q - WIN_W'(1);
		end else if (up_hi) begin
			step_pos = high_q;
		end else if (dn_lo) begin
			step_pos = low_q;
		end else begin
			step_pos = high_q - WIN_W'(1);
		end
	end

	assign sts.clr_done = (32'(clr_q) == CLR_DEPTH - 1);
	assign sts.pos_ok   = pos_ok_q;
	assign sts.in_win   = pos_ok_q && (pos_ext >= low_q) && (pos_ext < high_q);
	assign sts.bad      = bad;
	assign sts.move_any = up_lo || up_hi || dn_lo || dn_hi;
	assign sts.out_busy = out_valid_q && !out_ready;

	// Element store ports
	assign elm_we    = ctl.clear_en ? (32'(clr_q) < MAX_ELEMS) : ctl.ld_write;
	assign elm_waddr = ctl.clear_en ? clr_q[EIDX_W-1:0] : pos_q;
	assign elm_wdata = ctl.clear_en ? '0 : val_q;
	assign elm_raddr = ctl.rd_load ? pos_q : step_pos[EIDX_W-1:0];

	srdc_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(MAX_ELEMS)
	) u_elm_ram (
		.clk   (clk),
		.we    (elm_we),
		.waddr (elm_waddr),
		.wdata (elm_wdata),
		.raddr (elm_raddr),
		.rdata (elm_rdata)
	);

	// Count update: add sets a new distinct value, removal of the last copy drops one
	always_comb begin
		cnt_upd  = cnt_rdata;
		dist_upd = dist_q;
		if (up_q) begin
			cnt_upd = cnt_rdata + CNT_W'(1);
			if (cnt_rdata == '0) dist_upd = dist_q + WIN_W'(1);
		end else if (cnt_rdata != '0) begin
			cnt_upd = cnt_rdata - CNT_W'(1);
			if (cnt_rdata == CNT_W'(1) && dist_q != '0) dist_upd = dist_q - WIN_W'(1);
		end
	end

	// Count table ports
	assign cnt_we    = ctl.clear_en ? (32'(clr_q) < VSPAN) : ctl.cnt_write;
	assign cnt_waddr = ctl.clear_en ? clr_q[VALUE_BITS-1:0] : vidx_q;
	assign cnt_wdata = ctl.clear_en ? '0 : cnt_upd;
	assign cnt_raddr = ctl.cnt_rd_new ? val_q : elm_rdata;

	srdc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(VSPAN)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear_en && !sts.clr_done) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	// Latch transaction fields, saturating bounds to the store size; also latch the count address and update direction
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			pos_q    <= EIDX_W'(32'(position));
			pos_ok_q <= 32'(position) < MAX_ELEMS;
			val_q    <= VALUE_BITS'(32'(value));
			l_q      <= (32'(left_bound) > MAX_ELEMS) ? WIN_W'(MAX_ELEMS) :
			            WIN_W'(32'(left_bound));
			r_q      <= (32'(right_bound) > MAX_ELEMS) ? WIN_W'(MAX_ELEMS) :
			            WIN_W'(32'(right_bound));
		end
		if (ctl.cnt_rd_elem || ctl.cnt_rd_new) begin
			vidx_q <= cnt_raddr;
		end
		if (ctl.set_down) begin
			up_q <= 1'b0;
		end else if (ctl.set_up) begin
			up_q <= 1'b1;
		end else if (ctl.pick) begin
			up_q <= up_lo || up_hi;
		end
	end

	// Move window edges and track the distinct total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			dist_q <= '0;
		end else begin
			if (ctl.pick) begin
				if (up_lo) begin
					low_q <= low_q - WIN_W'(1);
				end else if (up_hi) begin
					high_q <= high_q + WIN_W'(1);
				end else if (dn_lo) begin
					low_q <= low_q + WIN_W'(1);
				end else begin
					high_q <= high_q - WIN_W'(1);
				end
			end
			if (ctl.cnt_write) begin
				dist_q <= dist_upd;
			end
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.result) begin
			distinct_q <= bad ? '0 : OUT_W'(dist_q);
			bad_q      <= bad;
		end
	end

	assign out_valid      = out_valid_q;
	assign distinct_count = distinct_q;
	assign bad_range      = bad_q;
endmodule

[hdl/sliding_range_distinct_counter.sv]
// Top level of the sliding range distinct counter.
// Counts distinct values in a half-open range [left_bound, right_bound) of an element
// store. A load transaction (cmd 0) writes one element if its position lies inside the
// store and gives no result; a query transaction (cmd 1) gives one result. After reset
// the block runs a clearing pass over the element store and the count table, with
// in_ready low. A load at a position inside the current window also updates the counts
// of the old and the loaded value. A query moves the window edges from the previous
// range one position per move, each move an element read followed by a read-modify-write
// of the count table; its last step is held while the previous result is still waiting
// in the output register. A query whose left bound exceeds its right bound, with both
// saturated to MAX_ELEMS, leaves the window as it is and returns bad_range with a zero
// count. The next transaction is taken while a result waits in the output register.
module sliding_range_distinct_counter #(
	parameter int MAX_ELEMS  = 4096,
	parameter int VALUE_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [srdc_pkg::POS_W-1:0]   position,
	input  logic [srdc_pkg::VAL_W-1:0]   value,
	input  logic [srdc_pkg::BOUND_W-1:0] left_bound,
	input  logic [srdc_pkg::BOUND_W-1:0] right_bound,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [srdc_pkg::OUT_W-1:0]   distinct_count,
	output logic                        bad_range
);
	import srdc_pkg::*;

	ctl_t ctl;
	sts_t sts;

	srdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	srdc_dp #(
		.MAX_ELEMS  (MAX_ELEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.position       (position),
		.value          (value),
		.left_bound     (left_bound),
		.right_bound    (right_bound),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.distinct_count (distinct_count),
		.bad_range      (bad_range)
	);
endmodule
